### sv/xxtea_pkg.sv
// shared types, constants and the mixing function of the xxtea block encrypt unit
package xxtea_pkg;

    localparam int unsigned XX_MAX_WORDS      = 4;
    localparam int unsigned XX_BLOCK_WORDS_DEF = 4;
    localparam logic [31:0] XX_DELTA          = 32'h9e37_79b9;
    localparam int unsigned XX_ROUND_BASE     = 6;
    localparam int unsigned XX_ROUND_SCALE    = 52;

    localparam logic [31:0] KEY0_RESET = 32'he5d9_f39a;
    localparam logic [31:0] KEY1_RESET = 32'h3686_790d;
    localparam logic [31:0] KEY2_RESET = 32'h7376_a4be;
    localparam logic [31:0] KEY3_RESET = 32'h5c2a_76c1;

    localparam int unsigned ADDR_W = 4;

    // register index codes (byte address bits 3:2)
    localparam logic [1:0] REG_KEY_0 = 2'd0;
    localparam logic [1:0] REG_KEY_1 = 2'd1;
    localparam logic [1:0] REG_KEY_2 = 2'd2;
    localparam logic [1:0] REG_KEY_3 = 2'd3;

    typedef struct packed {
        logic [31:0] plain_word_3;
        logic [31:0] plain_word_2;
        logic [31:0] plain_word_1;
        logic [31:0] plain_word_0;
    } t_plain;

    typedef struct packed {
        logic [31:0] cipher_word_3;
        logic [31:0] cipher_word_2;
        logic [31:0] cipher_word_1;
        logic [31:0] cipher_word_0;
    } t_cipher;

    typedef logic [31:0] t_word;

    // standard mx function, key word already selected
    function automatic t_word xx_mix(input t_word y, input t_word z,
                                     input t_word sum, input t_word key);
        t_word a;
        t_word b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key ^ z);
        return a ^ b;
    endfunction

endpackage

### sv/xxtea_block_encrypt_unit.sv
// xxtea block encryption, one word update per pipeline stage
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_stall         i_in_data  (t_plain)
//  out       output     o_out_valid / i_out_stall       o_out_data (t_cipher)
//  config    input      psel penable pwrite pready      paddr pwdata prdata
//
// one block enters per cycle while the pipeline moves, with one register stage for each
// word update of each round after the input register
// the whole pipeline moves together while the last stage is empty or its block is taken
// a one-block skid buffer at the input keeps o_in_stall registered
// synchronous active-low reset clears the valid bits and loads the default key
module xxtea_block_encrypt_unit
    import xxtea_pkg::*;
#(
    parameter int unsigned BLOCK_WORDS = XX_BLOCK_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_plain            i_in_data,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_cipher           o_out_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned ROUNDS = XX_ROUND_BASE + XX_ROUND_SCALE / BLOCK_WORDS;
    localparam int unsigned STAGES = ROUNDS * BLOCK_WORDS;

    logic [31:0] r_key [0:3];

    logic        r_vld  [0:STAGES];
    t_word       r_w    [0:STAGES][0:XX_MAX_WORDS-1];

    logic        r_skid_vld;
    t_plain      r_skid;

    logic        adv;
    logic        cfg_wr;
    t_plain      src;
    logic        src_vld;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY0_RESET;
            r_key[1] <= KEY1_RESET;
            r_key[2] <= KEY2_RESET;
            r_key[3] <= KEY3_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_KEY_0: r_key[0] <= pwdata;
                REG_KEY_1: r_key[1] <= pwdata;
                REG_KEY_2: r_key[2] <= pwdata;
                REG_KEY_3: r_key[3] <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_0: prdata = r_key[0];
            REG_KEY_1: prdata = r_key[1];
            REG_KEY_2: prdata = r_key[2];
            REG_KEY_3: prdata = r_key[3];
            default:   prdata = '0;
        endcase
    end

    // pipeline moves when the last stage is empty or being taken
    assign adv        = !r_vld[STAGES] || !i_out_stall;
    assign o_in_stall = r_skid_vld;
    assign src        = r_skid_vld ? r_skid : i_in_data;
    assign src_vld    = r_skid_vld || i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (adv) begin
            r_skid_vld <= 1'b0;
        end else if (i_in_valid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && i_in_valid && !r_skid_vld) begin
            r_skid <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= src_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w[0][0] <= src.plain_word_0;
            r_w[0][1] <= src.plain_word_1;
            r_w[0][2] <= src.plain_word_2;
            r_w[0][3] <= src.plain_word_3;
        end
    end

    // one word update per stage; round, word and sum are fixed per stage
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int unsigned RND   = s / BLOCK_WORDS;
        localparam int unsigned P     = s % BLOCK_WORDS;
        localparam int unsigned YI    = (P + 1) % BLOCK_WORDS;
        localparam int unsigned ZI    = (P + BLOCK_WORDS - 1) % BLOCK_WORDS;
        localparam logic [63:0] SUM_W = 64'(XX_DELTA) * 64'(RND + 1);
        localparam logic [31:0] SUM   = SUM_W[31:0];
        localparam logic [1:0]  KIDX  = 2'(P) ^ SUM[3:2];

        t_word mix_val;

        assign mix_val = xx_mix(r_w[s][YI], r_w[s][ZI], SUM, r_key[KIDX]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (adv) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int k = 0; k < XX_MAX_WORDS; k++) begin
                    if (k == int'(P)) begin
                        r_w[s+1][k] <= r_w[s][k] + mix_val;
                    end else begin
                        r_w[s+1][k] <= r_w[s][k];
                    end
                end
            end
        end
    end

    assign o_out_valid              = r_vld[STAGES];
    assign o_out_data.cipher_word_0 = r_w[STAGES][0];
    assign o_out_data.cipher_word_1 = r_w[STAGES][1];
    assign o_out_data.cipher_word_2 = r_w[STAGES][2];
    assign o_out_data.cipher_word_3 = r_w[STAGES][3];

endmodule
